// ===== design/http_response_byte_parser_macros.svh =====
// Assertion macros shared by the HTTP response byte parser.
`ifndef HTTP_RESPONSE_BYTE_PARSER_MACROS_SVH
`define HTTP_RESPONSE_BYTE_PARSER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define HRBP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define HRBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/hrbp_pkg.sv =====
// Types, codes and character helpers for the HTTP response byte parser.
`timescale 1ns / 1ps

package hrbp_pkg;

  // Default width of the internal length accumulator and body counter.
  localparam int LENGTH_WIDTH_DEF = 32;
  // Width of the reported content length.
  localparam int OUT_LEN_W = 32;

  // Length of the "content-length" header name.
  localparam logic [3:0] NAME_LEN = 4'd14;

  // Characters the parser looks for.
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // Phase codes reported with each result.
  localparam logic [2:0] PH_VERSION = 3'd0;
  localparam logic [2:0] PH_STATUS  = 3'd1;
  localparam logic [2:0] PH_REASON  = 3'd2;
  localparam logic [2:0] PH_NAME    = 3'd3;
  localparam logic [2:0] PH_VALUE   = 3'd4;
  localparam logic [2:0] PH_BODY    = 3'd5;
  localparam logic [2:0] PH_DONE    = 3'd6;
  localparam logic [2:0] PH_ERROR   = 3'd7;

  // Error codes.
  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_VERSION     = 3'd1;
  localparam logic [2:0] ERR_STATUS_CODE = 3'd2;
  localparam logic [2:0] ERR_STATUS_LINE = 3'd3;
  localparam logic [2:0] ERR_HEADER_NAME = 3'd4;
  localparam logic [2:0] ERR_MESSAGE     = 3'd5;
  localparam logic [2:0] ERR_BODY        = 3'd6;

  // Byte role codes.
  localparam logic [2:0] ROLE_SYNTAX  = 3'd0;
  localparam logic [2:0] ROLE_VDIGIT  = 3'd1;
  localparam logic [2:0] ROLE_SDIGIT  = 3'd2;
  localparam logic [2:0] ROLE_REASON  = 3'd3;
  localparam logic [2:0] ROLE_NAME    = 3'd4;
  localparam logic [2:0] ROLE_VALUE   = 3'd5;
  localparam logic [2:0] ROLE_BODY    = 3'd6;
  localparam logic [2:0] ROLE_IGNORED = 3'd7;

  // Main parse state, one-hot.
  typedef enum logic [14:0] {
    S_H      = 15'b000000000000001,
    S_T1     = 15'b000000000000010,
    S_T2     = 15'b000000000000100,
    S_P      = 15'b000000000001000,
    S_SLASH  = 15'b000000000010000,
    S_V1     = 15'b000000000100000,
    S_V2     = 15'b000000001000000,
    S_STATUS = 15'b000000010000000,
    S_REASON = 15'b000000100000000,
    S_LINE   = 15'b000001000000000,
    S_NAME   = 15'b000010000000000,
    S_VALUE  = 15'b000100000000000,
    S_BODY   = 15'b001000000000000,
    S_DONE   = 15'b010000000000000,
    S_ERR    = 15'b100000000000000
  } hrbp_state_t;

  // Progress through a content-length value, one-hot.
  typedef enum logic [3:0] {
    VP_BLANK  = 4'b0001,
    VP_SIGN   = 4'b0010,
    VP_DIGITS = 4'b0100,
    VP_END    = 4'b1000
  } hrbp_vphase_t;

  // Parser control state apart from the length counters.
  typedef struct packed {
    hrbp_state_t  parse_state;
    logic [2:0]   err_code;
    logic [1:0]   digits_left;
    logic [9:0]   status_acc;
    logic [3:0]   major_digit;
    logic [3:0]   minor_digit;
    logic [3:0]   name_match_pos;
    logic         name_mismatch;
    logic         in_length_value;
    logic         length_found;
    logic         length_neg;
    hrbp_vphase_t value_phase;
  } hrbp_ctrl_t;

  localparam hrbp_ctrl_t CTRL_RESET = '{
    parse_state:     S_H,
    err_code:        ERR_NONE,
    digits_left:     2'd0,
    status_acc:      10'd0,
    major_digit:     4'd0,
    minor_digit:     4'd0,
    name_match_pos:  4'd0,
    name_mismatch:   1'b0,
    in_length_value: 1'b0,
    length_found:    1'b0,
    length_neg:      1'b0,
    value_phase:     VP_BLANK
  };

  // One result transaction.
  typedef struct packed {
    logic [2:0]           phase;
    logic [2:0]           error_code;
    logic [2:0]           byte_role;
    logic [7:0]           field_byte;
    logic [9:0]           status_code;
    logic [3:0]           version_major;
    logic [3:0]           version_minor;
    logic [OUT_LEN_W-1:0] content_length;
    logic                 length_known;
    logic                 finished;
    logic                 errored;
    logic                 last_body_byte;
  } hrbp_result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  // Blanks skipped before a length value: space, tab, VT, FF, CR.
  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
  endfunction

  // Token characters allowed in a header name.
  function automatic logic is_name_char(input logic [7:0] c);
    logic r;
    case (c)
      8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A,
      8'h2B, 8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: begin
        r = 1'b1;
      end
      default: begin
        r = is_alpha(c) || is_digit(c);
      end
    endcase
    return r;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) ? (c + 8'h20) : c;
  endfunction

  // Character of "content-length" at a given position.
  function automatic logic [7:0] len_name_char(input logic [3:0] pos);
    logic [7:0] r;
    case (pos)
      4'd0:    r = 8'h63;
      4'd1:    r = 8'h6F;
      4'd2:    r = 8'h6E;
      4'd3:    r = 8'h74;
      4'd4:    r = 8'h65;
      4'd5:    r = 8'h6E;
      4'd6:    r = 8'h74;
      4'd7:    r = 8'h2D;
      4'd8:    r = 8'h6C;
      4'd9:    r = 8'h65;
      4'd10:   r = 8'h6E;
      4'd11:   r = 8'h67;
      4'd12:   r = 8'h74;
      4'd13:   r = 8'h68;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ===== design/hrbp_step.sv =====
// Per-byte next-state and result logic of the HTTP response byte parser.
`timescale 1ns / 1ps

module hrbp_step #(
  parameter int LENGTH_WIDTH = hrbp_pkg::LENGTH_WIDTH_DEF
) (
  input  hrbp_pkg::hrbp_ctrl_t   ctrl_i,
  input  logic [LENGTH_WIDTH-1:0] len_acc_i,
  input  logic [LENGTH_WIDTH-1:0] body_rem_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   new_message_i,
  output hrbp_pkg::hrbp_ctrl_t   ctrl_nxt,
  output logic [LENGTH_WIDTH-1:0] len_acc_nxt,
  output logic [LENGTH_WIDTH-1:0] body_rem_nxt,
  output hrbp_pkg::hrbp_result_t res_nxt
);

  localparam int OW = hrbp_pkg::OUT_LEN_W;

  hrbp_pkg::hrbp_ctrl_t    cur;
  logic [LENGTH_WIDTH-1:0] acc_cur;
  logic [LENGTH_WIDTH-1:0] rem_cur;
  logic [LENGTH_WIDTH-1:0] rem_dec;
  logic [LENGTH_WIDTH+3:0] acc_wide;
  logic [LENGTH_WIDTH+3:0] acc_mac;
  logic [LENGTH_WIDTH-1:0] acc_sat;
  logic [3:0]              digit;
  logic                    b_digit;
  logic [7:0]              b_lower;
  logic [9:0]              status_mac;
  logic [3:0]              match_base;
  logic                    match_hit;
  logic [2:0]              role;
  logic                    last;
  logic [2:0]              phase;
  logic [OW-1:0]           len_out;

  // A new message starts from the reset state before this byte is handled.
  assign cur     = new_message_i ? hrbp_pkg::CTRL_RESET : ctrl_i;
  assign acc_cur = new_message_i ? '0 : len_acc_i;
  assign rem_cur = new_message_i ? '0 : body_rem_i;

  // Byte classification.
  assign b_digit = hrbp_pkg::is_digit(data_byte_i);
  assign digit   = 4'(data_byte_i - hrbp_pkg::CH_ZERO);
  assign b_lower = hrbp_pkg::to_lower(data_byte_i);

  // Status digit accumulate: times ten by shifts, plus the new digit.
  assign status_mac = (cur.status_acc << 3) + (cur.status_acc << 1) + {6'd0, digit};

  // Length digit accumulate with saturation at the accumulator maximum.
  assign acc_wide = {4'd0, acc_cur};
  assign acc_mac  = (acc_wide << 3) + (acc_wide << 1) + {{LENGTH_WIDTH{1'b0}}, digit};
  assign acc_sat  = (|acc_mac[LENGTH_WIDTH+3:LENGTH_WIDTH]) ? '1 : acc_mac[LENGTH_WIDTH-1:0];

  // Body countdown that stops at zero.
  assign rem_dec = (rem_cur != '0) ? (rem_cur - LENGTH_WIDTH'(1)) : rem_cur;

  // Header name matcher: a fresh line starts over at position zero.
  assign match_base = (cur.parse_state == hrbp_pkg::S_LINE) ? 4'd0 : cur.name_match_pos;
  assign match_hit  = (match_base < hrbp_pkg::NAME_LEN) &&
                      (b_lower == hrbp_pkg::len_name_char(match_base));

  // Main parse step.
  always_comb begin
    ctrl_nxt     = cur;
    len_acc_nxt  = acc_cur;
    body_rem_nxt = rem_cur;
    role         = hrbp_pkg::ROLE_IGNORED;
    last         = 1'b0;
    case (cur.parse_state)
      hrbp_pkg::S_H: begin
        if (data_byte_i == hrbp_pkg::CH_H) begin
          ctrl_nxt.parse_state = hrbp_pkg::S_T1;
          role = hrbp_pkg::ROLE_SYNTAX;
        end else begin
          ctrl_nxt.parse_state = hrbp_pkg::S_ERR;
          ctrl_nxt.err_code    = hrbp_pkg::ERR_VERSION;
        end
      end
      hrbp_pkg::S_T1: begin
        if (data_byte_i == hrbp_pkg::CH_T) begin
          ctrl_nxt.parse_state = hrbp_pkg::S_T2;
          role = hrbp_pkg::ROLE_SYNTAX;
        end else begin
          ctrl_nxt.parse_state = hrbp_pkg::S_ERR;
          ctrl_nxt.err_code    = hrbp_pkg::ERR_VERSION;
        end
      end
      hrbp_pkg::S_T2: begin
        if (data_byte_i == hrbp_pkg::CH_T) begin
          ctrl_nxt.parse_state = hrbp_pkg::S_P;
          role = hrbp_pkg::ROLE_SYNTAX;
        end else begin
          ctrl_nxt.parse_state = hrbp_pkg::S_ERR;
          ctrl_nxt.err_code    = hrbp_pkg::ERR_VERSION;
        end
      end
      hrbp_pkg::S_P: begin
        if (data_byte_i == hrbp_pkg::CH_P) begin
          ctrl_nxt.parse_state = hrbp_pkg::S_SLASH;
          role = hrbp_pkg::ROLE_SYNTAX;
        end else begin
          ctrl_nxt.parse_state = hrbp_pkg::S_ERR;
          ctrl_nxt.err_code    = hrbp_pkg::ERR_VERSION;
        end
      end
      hrbp_pkg::S_SLASH: begin
        if (data_byte_i == hrbp_pkg::CH_SLASH) begin
          ctrl_nxt.parse_state = hrbp_pkg::S_V1;
          ctrl_nxt.digits_left = 2'd1;
          role = hrbp_pkg::ROLE_SYNTAX;
        end else begin
          ctrl_nxt.parse_state = hrbp_pkg::S_ERR;
          ctrl_nxt.err_code    = hrbp_pkg::ERR_VERSION;
        end
      end
      hrbp_pkg::S_V1: begin
        if ((cur.digits_left != 2'd0) && b_digit) begin
          ctrl_nxt.major_digit = digit;
          ctrl_nxt.digits_left = 2'd0;
          role = hrbp_pkg::ROLE_VDIGIT;
        end else if ((cur.digits_left == 2'd0) && (data_byte_i == hrbp_pkg::CH_DOT)) begin
          ctrl_nxt.parse_state = hrbp_pkg::S_V2;
          ctrl_nxt.digits_left = 2'd1;
          role = hrbp_pkg::ROLE_SYNTAX;
        end else begin
          ctrl_nxt.parse_state = hrbp_pkg::S_ERR;
          ctrl_nxt.err_code    = hrbp_pkg::ERR_VERSION;
        end
      end
      hrbp_pkg::S_V2: begin
        if ((cur.digits_left != 2'd0) && b_digit) begin
          ctrl_nxt.minor_digit = digit;
          ctrl_nxt.digits_left = 2'd0;
          role = hrbp_pkg::ROLE_VDIGIT;
        end else if ((cur.digits_left == 2'd0) && (data_byte_i == hrbp_pkg::CH_SPACE)) begin
          ctrl_nxt.parse_state = hrbp_pkg::S_STATUS;
          ctrl_nxt.digits_left = 2'd3;
          ctrl_nxt.status_acc  = 10'd0;
          role = hrbp_pkg::ROLE_SYNTAX;
        end else begin
          ctrl_nxt.parse_state = hrbp_pkg::S_ERR;
          ctrl_nxt.err_code    = hrbp_pkg::ERR_VERSION;
        end
      end
      hrbp_pkg::S_STATUS: begin
        if ((cur.digits_left != 2'd0) && b_digit) begin
          ctrl_nxt.status_acc  = status_mac;
          ctrl_nxt.digits_left = cur.digits_left - 2'd1;
          role = hrbp_pkg::ROLE_SDIGIT;
        end else if ((cur.digits_left == 2'd0) && (data_byte_i == hrbp_pkg::CH_SPACE)) begin
          ctrl_nxt.parse_state = hrbp_pkg::S_REASON;
          role = hrbp_pkg::ROLE_SYNTAX;
        end else begin
          ctrl_nxt.parse_state = hrbp_pkg::S_ERR;
          ctrl_nxt.err_code    = hrbp_pkg::ERR_STATUS_CODE;
        end
      end
      hrbp_pkg::S_REASON: begin
        if ((data_byte_i == hrbp_pkg::CH_SPACE) || hrbp_pkg::is_alpha(data_byte_i)) begin
          role = hrbp_pkg::ROLE_REASON;
        end else if (data_byte_i == hrbp_pkg::CH_LF) begin
          ctrl_nxt.parse_state = hrbp_pkg::S_LINE;
          role = hrbp_pkg::ROLE_SYNTAX;
        end else begin
          ctrl_nxt.parse_state = hrbp_pkg::S_ERR;
          ctrl_nxt.err_code    = hrbp_pkg::ERR_STATUS_LINE;
        end
      end
      hrbp_pkg::S_LINE: begin
        if (data_byte_i == hrbp_pkg::CH_LF) begin
          // The empty line ends the headers; the length decides what follows.
          if (!cur.length_found || (cur.length_neg && (acc_cur != '0))) begin
            ctrl_nxt.parse_state = hrbp_pkg::S_ERR;
            ctrl_nxt.err_code    = hrbp_pkg::ERR_BODY;
          end else if (acc_cur == '0) begin
            ctrl_nxt.parse_state = hrbp_pkg::S_DONE;
            role = hrbp_pkg::ROLE_SYNTAX;
          end else begin
            body_rem_nxt         = acc_cur;
            ctrl_nxt.parse_state = hrbp_pkg::S_BODY;
            role = hrbp_pkg::ROLE_SYNTAX;
          end
        end else if (hrbp_pkg::is_name_char(data_byte_i)) begin
          ctrl_nxt.name_match_pos = match_hit ? (match_base + 4'd1) : match_base;
          ctrl_nxt.name_mismatch  = !match_hit;
          ctrl_nxt.parse_state    = hrbp_pkg::S_NAME;
          role = hrbp_pkg::ROLE_NAME;
        end else begin
          ctrl_nxt.parse_state = hrbp_pkg::S_ERR;
          ctrl_nxt.err_code    = hrbp_pkg::ERR_MESSAGE;
        end
      end
      hrbp_pkg::S_NAME: begin
        if (hrbp_pkg::is_name_char(data_byte_i)) begin
          if (match_hit) begin
            ctrl_nxt.name_match_pos = match_base + 4'd1;
          end else begin
            ctrl_nxt.name_mismatch = 1'b1;
          end
          role = hrbp_pkg::ROLE_NAME;
        end else if (data_byte_i == hrbp_pkg::CH_COLON) begin
          // Only the first content-length header arms the value reader.
          if (!cur.name_mismatch && (cur.name_match_pos == hrbp_pkg::NAME_LEN) &&
              !cur.length_found) begin
            ctrl_nxt.length_found    = 1'b1;
            ctrl_nxt.in_length_value = 1'b1;
            ctrl_nxt.value_phase     = hrbp_pkg::VP_BLANK;
            ctrl_nxt.length_neg      = 1'b0;
            len_acc_nxt              = '0;
          end
          ctrl_nxt.parse_state = hrbp_pkg::S_VALUE;
          role = hrbp_pkg::ROLE_SYNTAX;
        end else begin
          ctrl_nxt.parse_state = hrbp_pkg::S_ERR;
          ctrl_nxt.err_code    = hrbp_pkg::ERR_HEADER_NAME;
        end
      end
      hrbp_pkg::S_VALUE: begin
        if (data_byte_i == hrbp_pkg::CH_LF) begin
          ctrl_nxt.in_length_value = 1'b0;
          ctrl_nxt.parse_state     = hrbp_pkg::S_LINE;
          role = hrbp_pkg::ROLE_SYNTAX;
        end else begin
          role = hrbp_pkg::ROLE_VALUE;
          if (cur.in_length_value) begin
            // Decimal value reader: blanks, optional sign, digits.
            case (cur.value_phase)
              hrbp_pkg::VP_BLANK: begin
                if (hrbp_pkg::is_blank(data_byte_i)) begin
                  ctrl_nxt.value_phase = hrbp_pkg::VP_BLANK;
                end else if (data_byte_i == hrbp_pkg::CH_PLUS) begin
                  ctrl_nxt.value_phase = hrbp_pkg::VP_SIGN;
                end else if (data_byte_i == hrbp_pkg::CH_MINUS) begin
                  ctrl_nxt.value_phase = hrbp_pkg::VP_SIGN;
                  ctrl_nxt.length_neg  = 1'b1;
                end else if (b_digit) begin
                  len_acc_nxt          = {{(LENGTH_WIDTH-4){1'b0}}, digit};
                  ctrl_nxt.value_phase = hrbp_pkg::VP_DIGITS;
                end else begin
                  ctrl_nxt.value_phase = hrbp_pkg::VP_END;
                end
              end
              hrbp_pkg::VP_SIGN, hrbp_pkg::VP_DIGITS: begin
                if (b_digit) begin
                  len_acc_nxt          = acc_sat;
                  ctrl_nxt.value_phase = hrbp_pkg::VP_DIGITS;
                end else begin
                  ctrl_nxt.value_phase = hrbp_pkg::VP_END;
                end
              end
              default: begin
                ctrl_nxt.value_phase = cur.value_phase;
              end
            endcase
          end
        end
      end
      hrbp_pkg::S_BODY: begin
        role         = hrbp_pkg::ROLE_BODY;
        body_rem_nxt = rem_dec;
        if (rem_dec == '0) begin
          ctrl_nxt.parse_state = hrbp_pkg::S_DONE;
          last = 1'b1;
        end
      end
      default: begin
        // Done and error hold until the next message.
        ctrl_nxt = cur;
      end
    endcase
  end

  // Phase after this byte.
  always_comb begin
    case (ctrl_nxt.parse_state)
      hrbp_pkg::S_H, hrbp_pkg::S_T1, hrbp_pkg::S_T2, hrbp_pkg::S_P,
      hrbp_pkg::S_SLASH, hrbp_pkg::S_V1, hrbp_pkg::S_V2: phase = hrbp_pkg::PH_VERSION;
      hrbp_pkg::S_STATUS:                                phase = hrbp_pkg::PH_STATUS;
      hrbp_pkg::S_REASON:                                phase = hrbp_pkg::PH_REASON;
      hrbp_pkg::S_LINE, hrbp_pkg::S_NAME:                phase = hrbp_pkg::PH_NAME;
      hrbp_pkg::S_VALUE:                                 phase = hrbp_pkg::PH_VALUE;
      hrbp_pkg::S_BODY:                                  phase = hrbp_pkg::PH_BODY;
      hrbp_pkg::S_ERR:                                   phase = hrbp_pkg::PH_ERROR;
      default:                                           phase = hrbp_pkg::PH_DONE;
    endcase
  end

  // Reported length: saturate a wider accumulator, extend a narrower one.
  generate
    if (LENGTH_WIDTH > OW) begin : g_len_wide
      assign len_out = (|len_acc_nxt[LENGTH_WIDTH-1:OW]) ? '1 : len_acc_nxt[OW-1:0];
    end else if (LENGTH_WIDTH == OW) begin : g_len_same
      assign len_out = len_acc_nxt;
    end else begin : g_len_narrow
      assign len_out = {{(OW-LENGTH_WIDTH){1'b0}}, len_acc_nxt};
    end
  endgenerate

  // Result fields.
  always_comb begin
    res_nxt.phase          = phase;
    res_nxt.error_code     = (ctrl_nxt.parse_state == hrbp_pkg::S_ERR) ?
                             ctrl_nxt.err_code : hrbp_pkg::ERR_NONE;
    res_nxt.byte_role      = role;
    res_nxt.field_byte     = data_byte_i;
    res_nxt.status_code    = ctrl_nxt.status_acc;
    res_nxt.version_major  = ctrl_nxt.major_digit;
    res_nxt.version_minor  = ctrl_nxt.minor_digit;
    res_nxt.content_length = len_out;
    res_nxt.length_known   = ctrl_nxt.length_found;
    res_nxt.finished       = (phase == hrbp_pkg::PH_DONE) || (phase == hrbp_pkg::PH_ERROR);
    res_nxt.errored        = (phase == hrbp_pkg::PH_ERROR);
    res_nxt.last_body_byte = last;
  end

endmodule

// ===== design/http_response_byte_parser.sv =====
// HTTP response byte parser: one byte per cycle, result per byte.
//
// Input channel (in_valid/in_ready) carries one byte of the response stream
// per transaction, with in_new_message to restart parsing at that byte.
// Output channel (out_valid/out_ready) returns one result transaction per
// input byte: phase, error code, role of the byte, the byte itself, and the
// status line and content-length values gathered so far.
// The result of a byte sits in the output register on the cycle after it is
// accepted. Throughput is one byte per cycle, set by the single parse step
// between the state registers and the output register.
// While the output register holds a result that has not been taken, a new
// byte is still accepted in the same cycle that the result leaves; if the
// receiver stalls, in_ready drops and the parse state holds.
// Reset (rst_n low, synchronous) empties the output register and returns the
// parser to expecting the start of a status line. Errors stay until a byte
// arrives with in_new_message set.
`timescale 1ns / 1ps
`include "http_response_byte_parser_macros.svh"

module http_response_byte_parser #(
  parameter int LENGTH_WIDTH = hrbp_pkg::LENGTH_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_new_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_phase,
  output logic [2:0]  out_error_code,
  output logic [2:0]  out_byte_role,
  output logic [7:0]  out_field_byte,
  output logic [9:0]  out_status_code,
  output logic [3:0]  out_version_major,
  output logic [3:0]  out_version_minor,
  output logic [31:0] out_content_length,
  output logic        out_length_known,
  output logic        out_finished,
  output logic        out_errored,
  output logic        out_last_body_byte
);

  hrbp_pkg::hrbp_ctrl_t    ctrl_r;
  hrbp_pkg::hrbp_ctrl_t    ctrl_nxt;
  logic [LENGTH_WIDTH-1:0] len_acc_r;
  logic [LENGTH_WIDTH-1:0] len_acc_nxt;
  logic [LENGTH_WIDTH-1:0] body_rem_r;
  logic [LENGTH_WIDTH-1:0] body_rem_nxt;
  hrbp_pkg::hrbp_result_t  res_r;
  hrbp_pkg::hrbp_result_t  res_nxt;
  logic                    out_valid_r;
  logic                    in_fire;

  // A byte is taken whenever the output register is empty or being emptied.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Parse step for the incoming byte.
  hrbp_step #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_step (
    .ctrl_i       (ctrl_r),
    .len_acc_i    (len_acc_r),
    .body_rem_i   (body_rem_r),
    .data_byte_i  (in_data_byte),
    .new_message_i(in_new_message),
    .ctrl_nxt     (ctrl_nxt),
    .len_acc_nxt  (len_acc_nxt),
    .body_rem_nxt (body_rem_nxt),
    .res_nxt      (res_nxt)
  );

  // Parser state and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r      <= hrbp_pkg::CTRL_RESET;
      len_acc_r   <= '0;
      body_rem_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        ctrl_r     <= ctrl_nxt;
        len_acc_r  <= len_acc_nxt;
        body_rem_r <= body_rem_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_phase          = res_r.phase;
  assign out_error_code     = res_r.error_code;
  assign out_byte_role      = res_r.byte_role;
  assign out_field_byte     = res_r.field_byte;
  assign out_status_code    = res_r.status_code;
  assign out_version_major  = res_r.version_major;
  assign out_version_minor  = res_r.version_minor;
  assign out_content_length = res_r.content_length;
  assign out_length_known   = res_r.length_known;
  assign out_finished       = res_r.finished;
  assign out_errored        = res_r.errored;
  assign out_last_body_byte = res_r.last_body_byte;

  // The body counter is never zero while body bytes are still expected.
  `HRBP_ASSERT_NOW(a_body_rem_nonzero, clk, rst_n, ctrl_r.parse_state == hrbp_pkg::S_BODY, body_rem_r != '0, "body state with zero bytes remaining")

  // An error holds its code until a new message starts.
  `HRBP_ASSERT_NEXT(a_error_sticky, clk, rst_n, in_fire && !in_new_message && ctrl_r.parse_state == hrbp_pkg::S_ERR, ctrl_r.parse_state == hrbp_pkg::S_ERR && ctrl_r.err_code == $past(ctrl_r.err_code), "error state left without a new message")

  // A result that closes the body leaves the parser done.
  `HRBP_ASSERT_NOW(a_last_done, clk, rst_n, out_valid_r && res_r.last_body_byte, ctrl_r.parse_state == hrbp_pkg::S_DONE && res_r.phase == hrbp_pkg::PH_DONE, "last body byte without done state")

endmodule
